// ----- rtl/assert_macros.svh -----
// assertion helpers used by range_distinct_count_core
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, sampled on aclk, off while in reset
`define RDC_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("rdc assertion failed");

// next-cycle implication, sampled on aclk, off while in reset
`define RDC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("rdc assertion failed");

`endif

// ----- rtl/rdc_pkg.sv -----
// ----------------------------------------------------------------------------
// rdc_pkg
// shared sizes, command codes, controller states and interface structs
// ----------------------------------------------------------------------------
package rdc_pkg;

    localparam int MAX_LENGTH  = 4096;
    localparam int VALUE_COUNT = 4096;

    localparam int VAL_W  = 12;
    localparam int POS_W  = $clog2(MAX_LENGTH + 1);
    localparam int SEQ_AW = $clog2(MAX_LENGTH);
    localparam int CNT_AW = $clog2(VALUE_COUNT);
    localparam int CNT_W  = $clog2(MAX_LENGTH + 1);

    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_STEP,
        ST_VAL,
        ST_UPD,
        ST_DONE
    } rdc_state_t;

    typedef struct packed {
        logic [POS_W-1:0] distinct;
        logic             bad_range;
    } rdc_res_t;

    typedef struct packed {
        logic clearing;
        logic query_busy;
    } rdc_stat_t;

endpackage

// ----- rtl/rdc_ram.sv -----
// ----------------------------------------------------------------------------
// rdc_ram
// simple dual-port ram, one write and one registered read per cycle
// ----------------------------------------------------------------------------
module rdc_ram #(
    parameter int DEPTH = 4096,
    parameter int WIDTH = 12
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        rdata <= mem[raddr];
    end

endmodule

// ----- rtl/rdc_ctrl.sv -----
// ----------------------------------------------------------------------------
// rdc_ctrl
// window walker: clears the count memory, loads the sequence store, moves the window edges one
// position at a time and read-modify-writes the count memory
// ----------------------------------------------------------------------------
module rdc_ctrl (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic                      s_command,
    input  logic [rdc_pkg::VAL_W-1:0] s_value,
    input  logic [rdc_pkg::POS_W-1:0] s_lo,
    input  logic [rdc_pkg::POS_W-1:0] s_hi,
    output logic                      seq_we,
    output logic [rdc_pkg::SEQ_AW-1:0] seq_waddr,
    output logic [rdc_pkg::VAL_W-1:0] seq_wdata,
    output logic [rdc_pkg::SEQ_AW-1:0] seq_raddr,
    input  logic [rdc_pkg::VAL_W-1:0] seq_rdata,
    output logic                      cnt_we,
    output logic [rdc_pkg::CNT_AW-1:0] cnt_waddr,
    output logic [rdc_pkg::CNT_W-1:0] cnt_wdata,
    output logic [rdc_pkg::CNT_AW-1:0] cnt_raddr,
    input  logic [rdc_pkg::CNT_W-1:0] cnt_rdata,
    output logic                      res_valid,
    input  logic                      res_ready,
    output rdc_pkg::rdc_res_t         res,
    output rdc_pkg::rdc_stat_t        stat
);
    import rdc_pkg::*;

    rdc_state_t        state_reg, state_next;
    logic [CNT_AW-1:0] clr_reg, clr_next;
    logic [POS_W-1:0]  len_reg, len_next;
    logic [POS_W-1:0]  left_reg, left_next;
    logic [POS_W-1:0]  right_reg, right_next;
    logic [POS_W-1:0]  dist_reg, dist_next;
    logic [POS_W-1:0]  lo_reg, lo_next;
    logic [POS_W-1:0]  hi_reg, hi_next;
    logic              inc_reg, inc_next;
    logic [CNT_AW-1:0] val_reg, val_next;
    rdc_res_t          res_reg, res_next;

    logic [POS_W-1:0]  step_pos;
    logic [POS_W-1:0]  step_pos_m1;
    logic [POS_W-1:0]  value_ext;
    logic [VAL_W-1:0]  value_clamped;
    logic              query_bad;

    // loaded values beyond the count table fold onto its last entry
    assign value_ext     = POS_W'(s_value);
    assign value_clamped = (value_ext >= POS_W'(VALUE_COUNT)) ?
                           VAL_W'(VALUE_COUNT - 1) : s_value;
    assign query_bad     = (s_lo == '0) || (s_lo > s_hi) || (s_hi > len_reg);

    assign res  = res_reg;
    assign stat = '{clearing: (state_reg == ST_CLEAR),
                    query_busy: (state_reg == ST_STEP) || (state_reg == ST_VAL) ||
                                (state_reg == ST_UPD)};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
            clr_reg   <= '0;
            len_reg   <= '0;
            left_reg  <= POS_W'(1);
            right_reg <= '0;
            dist_reg  <= '0;
        end else begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            len_reg   <= len_next;
            left_reg  <= left_next;
            right_reg <= right_next;
            dist_reg  <= dist_next;
        end
        lo_reg  <= lo_next;
        hi_reg  <= hi_next;
        inc_reg <= inc_next;
        val_reg <= val_next;
        res_reg <= res_next;
    end

    always_comb begin
        state_next = state_reg;
        clr_next   = clr_reg;
        len_next   = len_reg;
        left_next  = left_reg;
        right_next = right_reg;
        dist_next  = dist_reg;
        lo_next    = lo_reg;
        hi_next    = hi_reg;
        inc_next   = inc_reg;
        val_next   = val_reg;
        res_next   = res_reg;
        step_pos   = left_reg;
        s_ready    = 1'b0;
        seq_we     = 1'b0;
        seq_waddr  = len_reg[SEQ_AW-1:0];
        seq_wdata  = value_clamped;
        cnt_we     = 1'b0;
        cnt_waddr  = val_reg;
        cnt_wdata  = '0;
        cnt_raddr  = seq_rdata[CNT_AW-1:0];
        res_valid  = 1'b0;

        case (state_reg)
            ST_CLEAR: begin
                cnt_we    = 1'b1;
                cnt_waddr = clr_reg;
                cnt_wdata = '0;
                clr_next  = clr_reg + CNT_AW'(1);
                if (clr_reg == CNT_AW'(VALUE_COUNT - 1)) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    if (s_command == CMD_LOAD) begin
                        if (len_reg < POS_W'(MAX_LENGTH)) begin
                            seq_we   = 1'b1;
                            len_next = len_reg + POS_W'(1);
                        end
                    end else if (query_bad) begin
                        res_next   = '{distinct: '0, bad_range: 1'b1};
                        state_next = ST_DONE;
                    end else begin
                        lo_next    = s_lo;
                        hi_next    = s_hi;
                        state_next = ST_STEP;
                    end
                end
            end
            ST_STEP: begin
                // grow first, then shrink
                if (left_reg > lo_reg) begin
                    step_pos   = left_reg - POS_W'(1);
                    left_next  = step_pos;
                    inc_next   = 1'b1;
                    state_next = ST_VAL;
                end else if (right_reg < hi_reg) begin
                    step_pos   = right_reg + POS_W'(1);
                    right_next = step_pos;
                    inc_next   = 1'b1;
                    state_next = ST_VAL;
                end else if (left_reg < lo_reg) begin
                    step_pos   = left_reg;
                    left_next  = left_reg + POS_W'(1);
                    inc_next   = 1'b0;
                    state_next = ST_VAL;
                end else if (right_reg > hi_reg) begin
                    step_pos   = right_reg;
                    right_next = right_reg - POS_W'(1);
                    inc_next   = 1'b0;
                    state_next = ST_VAL;
                end else begin
                    res_next   = '{distinct: dist_reg, bad_range: 1'b0};
                    state_next = ST_DONE;
                end
            end
            ST_VAL: begin
                cnt_raddr  = seq_rdata[CNT_AW-1:0];
                val_next   = seq_rdata[CNT_AW-1:0];
                state_next = ST_UPD;
            end
            ST_UPD: begin
                cnt_waddr = val_reg;
                if (inc_reg) begin
                    cnt_we    = 1'b1;
                    cnt_wdata = cnt_rdata + CNT_W'(1);
                    if (cnt_rdata == '0) begin
                        dist_next = dist_reg + POS_W'(1);
                    end
                end else if (cnt_rdata != '0) begin
                    cnt_we    = 1'b1;
                    cnt_wdata = cnt_rdata - CNT_W'(1);
                    if ((cnt_rdata == CNT_W'(1)) && (dist_reg != '0)) begin
                        dist_next = dist_reg - POS_W'(1);
                    end
                end
                state_next = ST_STEP;
            end
            ST_DONE: begin
                res_valid = 1'b1;
                if (res_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        // positions are one-based, the store is zero-based
        step_pos_m1 = step_pos - POS_W'(1);
        seq_raddr   = step_pos_m1[SEQ_AW-1:0];
    end

endmodule

// ----- rtl/range_distinct_count_core.sv -----
// ----------------------------------------------------------------------------
// range_distinct_count_core
// distinct values in a range of a loaded sequence, using a sliding window
// over a sequence store and a per-value count memory
// ----------------------------------------------------------------------------
//  channel  dir  ports                                   beat
//  s_       in   s_command s_value s_lo s_hi             load or query
//  m_       out  m_distinct m_bad_range                  one per query
//
//  load: written to the sequence store from the idle state. query: the window edges
//  move one position at a time, each move a sequence read, count read and count
//  write-back on the count memory port. rejected query: answered with m_bad_range set.
//  after reset the count memory is cleared, s_ready held low.
//  the result register frees the walker while m_ready is low only when it is empty.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module range_distinct_count_core (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic                      s_command,
    input  logic [rdc_pkg::VAL_W-1:0] s_value,
    input  logic [rdc_pkg::POS_W-1:0] s_lo,
    input  logic [rdc_pkg::POS_W-1:0] s_hi,
    output logic                      m_valid,
    input  logic                      m_ready,
    output logic [rdc_pkg::POS_W-1:0] m_distinct,
    output logic                      m_bad_range
);
    import rdc_pkg::*;

    logic              seq_we;
    logic [SEQ_AW-1:0] seq_waddr;
    logic [VAL_W-1:0]  seq_wdata;
    logic [SEQ_AW-1:0] seq_raddr;
    logic [VAL_W-1:0]  seq_rdata;
    logic              cnt_we;
    logic [CNT_AW-1:0] cnt_waddr;
    logic [CNT_W-1:0]  cnt_wdata;
    logic [CNT_AW-1:0] cnt_raddr;
    logic [CNT_W-1:0]  cnt_rdata;
    logic              res_valid;
    logic              res_ready;
    rdc_res_t          res;
    rdc_stat_t         stat;

    logic              m_valid_reg, m_valid_next;
    rdc_res_t          m_res_reg, m_res_next;

    rdc_ram #(.DEPTH(MAX_LENGTH), .WIDTH(VAL_W)) u_seq_ram (
        .aclk  (aclk),
        .we    (seq_we),
        .waddr (seq_waddr),
        .wdata (seq_wdata),
        .raddr (seq_raddr),
        .rdata (seq_rdata)
    );

    rdc_ram #(.DEPTH(VALUE_COUNT), .WIDTH(CNT_W)) u_cnt_ram (
        .aclk  (aclk),
        .we    (cnt_we),
        .waddr (cnt_waddr),
        .wdata (cnt_wdata),
        .raddr (cnt_raddr),
        .rdata (cnt_rdata)
    );

    rdc_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_command (s_command),
        .s_value   (s_value),
        .s_lo      (s_lo),
        .s_hi      (s_hi),
        .seq_we    (seq_we),
        .seq_waddr (seq_waddr),
        .seq_wdata (seq_wdata),
        .seq_raddr (seq_raddr),
        .seq_rdata (seq_rdata),
        .cnt_we    (cnt_we),
        .cnt_waddr (cnt_waddr),
        .cnt_wdata (cnt_wdata),
        .cnt_raddr (cnt_raddr),
        .cnt_rdata (cnt_rdata),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res),
        .stat      (stat)
    );

    // output register
    assign res_ready = !m_valid_reg || m_ready;

    always_comb begin
        m_valid_next = m_valid_reg;
        m_res_next   = m_res_reg;
        if (res_valid && res_ready) begin
            m_valid_next = 1'b1;
            m_res_next   = res;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
        m_res_reg <= m_res_next;
    end

    assign m_valid     = m_valid_reg;
    assign m_distinct  = m_res_reg.distinct;
    assign m_bad_range = m_res_reg.bad_range;

    `RDC_ASSERT_SAME(a_clear_blocks_input, stat.clearing, !s_ready)
    `RDC_ASSERT_SAME(a_walk_blocks_input, stat.query_busy, !s_ready && !res_valid)
    `RDC_ASSERT_SAME(a_bad_gives_zero, res_valid && res.bad_range, res.distinct == '0)
    `RDC_ASSERT_NEXT(a_result_lands, res_valid && res_ready, m_valid)

endmodule
